// File: rtl/gcr_pkg.sv
// Shared types and constants of the grid ray caster.
`default_nettype none
package gcr_pkg;

	// Default map side in cells, cell width as a shift (log2 of the width in world units)
	localparam int MAP_SIDE_DEF = 32;
	localparam int CELL_SHIFT   = 6;

	// Input and trig field widths
	localparam int TRIG_W  = 18;
	localparam int START_W = 11;

	// Crossing bound before the ray is given up
	localparam int MAX_STEPS = 4096;
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);

	// Largest cell value that is not a wall
	localparam logic [7:0] WALL_LIMIT = 8'd127;

	// Distance reported when nothing is struck
	localparam logic [30:0] NO_HIT_DIST = 31'h7FFF_FFFF;

	// Bit width of the per-crossing quotient (it never exceeds 64)
	localparam int STEP_Q_W = 7;

	// Request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CAST  = 1'b1;

	// Face codes
	localparam logic [1:0] FACE_EAST  = 2'd0;
	localparam logic [1:0] FACE_NORTH = 2'd1;
	localparam logic [1:0] FACE_WEST  = 2'd2;
	localparam logic [1:0] FACE_SOUTH = 2'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SEL,
		ST_DIV,
		ST_UPD,
		ST_RD,
		ST_CHK
	} state_t;

endpackage
`default_nettype wire

// File: rtl/gcr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module gcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Store on write, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/grid_ray_caster.sv
// Top level of the grid ray caster: cell map RAM and boundary-stepping sequencer.
//
//  channel   | handshake            | fields
//  ----------+----------------------+-----------------------------------------------
//  request   | start, busy          | req_type cell_x cell_y cell_value start_x
//            |                      | start_y ray_sine ray_cosine
//  result    | done (one-cycle)     | hit_value hit_face texture_offset
//            |                      | travel_distance never_hit
//
// A write item leaves the block idle, ready for the next item. A cast runs one
// sequence for each cell boundary crossed (two products, boundary pick, a 7-step
// quotient, update, RAM read, check) and, on a hit, the final distance quotient,
// all through one shared bit-serial divider. The map needs no clearing after reset;
// cells read before they are written are undefined. Results cannot be held off:
// done lasts one cycle and the next item may start in that same cycle.
`default_nettype none
module grid_ray_caster
	import gcr_pkg::*;
#(
	parameter int MAP_SIDE = MAP_SIDE_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     req_type,
	input  wire logic [4:0]               cell_x,
	input  wire logic [4:0]               cell_y,
	input  wire logic [7:0]               cell_value,
	input  wire logic [START_W-1:0]       start_x,
	input  wire logic [START_W-1:0]       start_y,
	input  wire logic signed [TRIG_W-1:0] ray_sine,
	input  wire logic signed [TRIG_W-1:0] ray_cosine,
	output logic                          done,
	output logic [7:0]                    hit_value,
	output logic [1:0]                    hit_face,
	output logic [5:0]                    texture_offset,
	output logic [30:0]                   travel_distance,
	output logic                          never_hit
);

	localparam int MAP_LOG = $clog2(MAP_SIDE);
	localparam int CW      = ((MAP_LOG + CELL_SHIFT > START_W) ?
		MAP_LOG + CELL_SHIFT : START_W) + 2;
	localparam int DW      = CW + 16;
	localparam int RW      = TRIG_W + 1;
	localparam int PW      = 8 + TRIG_W;
	localparam int CNTW    = $clog2(DW + 1);
	localparam int DEPTH   = MAP_SIDE * MAP_SIDE;
	localparam int AW      = $clog2(DEPTH);
	localparam logic signed [CW-1:0] LIM = CW'(MAP_SIDE * 64);

	state_t state_q, state_n;

	// Ray registers
	logic signed [CW-1:0]     x_q, y_q;
	logic [START_W-1:0]       sx_q, sy_q;
	logic signed [TRIG_W-1:0] sn_q, cs_q;
	logic [STEP_W-1:0]        steps_q;
	logic signed [7:0]        dx_q, dy_q;
	logic signed [PW-1:0]     px_q, py_q;
	logic                     xbr_q;
	logic                     in_map_q;

	// Divider registers
	logic [RW-1:0]     div_rem_q;
	logic [DW-1:0]     div_num_q;
	logic [DW-1:0]     div_quo_q;
	logic [TRIG_W-1:0] div_den_q;
	logic [CNTW-1:0]   div_cnt_q;
	logic              div_neg_q;
	logic              dist_q;

	// Result registers
	logic        done_q;
	logic [7:0]  hit_value_q;
	logic [1:0]  hit_face_q;
	logic [5:0]  tex_q;
	logic [30:0] dist_out_q;
	logic        never_hit_q;

	// Combinational helpers
	logic signed [7:0]    dx_c, dy_c;
	logic [PW-2:0]        pxm_c, pym_c, pm_c;
	logic                 pick_x_c;
	logic [TRIG_W-1:0]    snm_c, csm_c;
	logic [RW:0]          div_t_c;
	logic                 div_ge_c;
	logic [RW-1:0]        div_rem_n;
	logic [DW-1:0]        div_quo_n;
	logic signed [7:0]    qd_c;
	logic [7:0]           cell_v_c;
	logic                 wall_c, outward_c, zero_dir_c;
	logic signed [CW-1:0] diff_c;
	logic [CW-1:0]        diffm_c;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [7:0]           ram_rdata;
	logic                 accept_c;

	gcr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cell_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Distances to the next boundary, products and their magnitudes
	always_comb begin
		dx_c  = (cs_q > 0) ? 8'sd64 - $signed({2'b00, x_q[5:0]})
			: -8'sd1 - $signed({2'b00, x_q[5:0]});
		dy_c  = (sn_q > 0) ? 8'sd64 - $signed({2'b00, y_q[5:0]})
			: -8'sd1 - $signed({2'b00, y_q[5:0]});
		pxm_c = (PW-1)'(px_q[PW-1] ? -px_q : px_q);
		pym_c = (PW-1)'(py_q[PW-1] ? -py_q : py_q);
		pick_x_c = pxm_c < pym_c;
		pm_c  = pick_x_c ? pxm_c : pym_c;
		snm_c = TRIG_W'(sn_q[TRIG_W-1] ? -sn_q : sn_q);
		csm_c = TRIG_W'(cs_q[TRIG_W-1] ? -cs_q : cs_q);
		zero_dir_c = (ray_sine == '0) && (ray_cosine == '0);
	end

	// One restoring step of the shared divider
	always_comb begin
		div_t_c   = {div_rem_q, div_num_q[DW-1]};
		div_ge_c  = div_t_c >= {2'b00, div_den_q};
		div_rem_n = div_ge_c ? RW'(div_t_c - {2'b00, div_den_q}) : RW'(div_t_c);
		div_quo_n = {div_quo_q[DW-2:0], div_ge_c};
		qd_c      = div_neg_q ? -$signed({1'b0, div_quo_q[STEP_Q_W-1:0]})
			: $signed({1'b0, div_quo_q[STEP_Q_W-1:0]});
	end

	// Cell check after the read
	always_comb begin
		cell_v_c  = in_map_q ? ram_rdata : 8'd0;
		wall_c    = cell_v_c > WALL_LIMIT;
		outward_c = ((sn_q < 0) && (y_q < 0)) || ((sn_q > 0) && (y_q >= LIM)) ||
			((cs_q < 0) && (x_q < 0)) || ((cs_q > 0) && (x_q >= LIM));
		diff_c    = xbr_q ? x_q - CW'(sx_q) : y_q - CW'(sy_q);
		diffm_c   = diff_c[CW-1] ? CW'(-diff_c) : CW'(diff_c);
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_c && req_type == REQ_CAST && !zero_dir_c) begin
					state_n = ST_MUL;
				end
			end
			ST_MUL: begin
				state_n = (steps_q == STEP_W'(MAX_STEPS)) ? ST_IDLE : ST_SEL;
			end
			ST_SEL: state_n = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == CNTW'(1)) begin
					state_n = dist_q ? ST_IDLE : ST_UPD;
				end
			end
			ST_UPD: state_n = ST_RD;
			ST_RD:  state_n = ST_CHK;
			ST_CHK: begin
				if (wall_c) begin
					state_n = ST_DIV;
				end else if (cell_v_c == 8'd0 && outward_c) begin
					state_n = ST_IDLE;
				end else begin
					state_n = ST_MUL;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Handshake and map port controls
	always_comb begin
		busy      = state_q != ST_IDLE;
		accept_c  = start && !busy;
		ram_we    = accept_c && req_type == REQ_WRITE &&
			(32'(cell_x) < MAP_SIDE) && (32'(cell_y) < MAP_SIDE);
		ram_waddr = AW'(AW'(cell_y) * AW'(MAP_SIDE)) + AW'(cell_x);
		ram_re    = state_q == ST_RD;
		ram_raddr = AW'(AW'(y_q[CW-2:CELL_SHIFT]) * AW'(MAP_SIDE)) +
			AW'(x_q[CW-2:CELL_SHIFT]);
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= (accept_c && req_type == REQ_CAST && zero_dir_c) ||
				(state_q == ST_MUL && steps_q == STEP_W'(MAX_STEPS)) ||
				(state_q == ST_DIV && div_cnt_q == CNTW'(1) && dist_q) ||
				(state_q == ST_CHK && !wall_c && cell_v_c == 8'd0 && outward_c);
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// latch the ray, or report a miss for a zero direction
				if (accept_c && req_type == REQ_CAST) begin
					x_q     <= CW'(start_x);
					y_q     <= CW'(start_y);
					sx_q    <= start_x;
					sy_q    <= start_y;
					sn_q    <= ray_sine;
					cs_q    <= ray_cosine;
					steps_q <= '0;
					if (zero_dir_c) begin
						hit_value_q <= 8'd0;
						hit_face_q  <= FACE_EAST;
						tex_q       <= 6'd0;
						dist_out_q  <= NO_HIT_DIST;
						never_hit_q <= 1'b1;
					end
				end
			end
			ST_MUL: begin
				// form both cross products, drop the ray at the step bound
				dx_q    <= dx_c;
				dy_q    <= dy_c;
				px_q    <= PW'(dx_c) * PW'(sn_q);
				py_q    <= PW'(dy_c) * PW'(cs_q);
				steps_q <= steps_q + 1'b1;
				if (steps_q == STEP_W'(MAX_STEPS)) begin
					hit_value_q <= 8'd0;
					hit_face_q  <= FACE_EAST;
					tex_q       <= 6'd0;
					dist_out_q  <= NO_HIT_DIST;
					never_hit_q <= 1'b1;
				end
			end
			ST_SEL: begin
				// pick the nearer boundary and load the divider
				xbr_q     <= pick_x_c;
				div_den_q <= pick_x_c ? csm_c : snm_c;
				div_neg_q <= pick_x_c ? (px_q[PW-1] ^ cs_q[TRIG_W-1])
					: (py_q[PW-1] ^ sn_q[TRIG_W-1]);
				div_rem_q <= RW'(pm_c >> STEP_Q_W);
				div_num_q <= {pm_c[STEP_Q_W-1:0], {(DW-STEP_Q_W){1'b0}}};
				div_quo_q <= '0;
				div_cnt_q <= CNTW'(STEP_Q_W);
				dist_q    <= 1'b0;
			end
			ST_DIV: begin
				// advance one quotient bit
				div_rem_q <= div_rem_n;
				div_num_q <= div_num_q << 1;
				div_quo_q <= div_quo_n;
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == CNTW'(1) && dist_q) begin
					dist_out_q <= 31'(div_quo_n);
				end
			end
			ST_UPD: begin
				// move to the chosen boundary
				if (xbr_q) begin
					x_q <= x_q + CW'(dx_q);
					y_q <= y_q + CW'(qd_c);
				end else begin
					x_q <= x_q + CW'(qd_c);
					y_q <= y_q + CW'(dy_q);
				end
			end
			ST_RD: begin
				in_map_q <= !x_q[CW-1] && !y_q[CW-1] && (x_q < LIM) && (y_q < LIM);
			end
			ST_CHK: begin
				// on a wall, record the face and start the distance quotient
				if (wall_c) begin
					hit_value_q <= cell_v_c;
					never_hit_q <= 1'b0;
					if (xbr_q) begin
						hit_face_q <= (cs_q > 0) ? FACE_WEST : FACE_EAST;
						tex_q      <= (cs_q > 0) ? ~y_q[5:0] : y_q[5:0];
						div_den_q  <= csm_c;
					end else begin
						hit_face_q <= (sn_q > 0) ? FACE_SOUTH : FACE_NORTH;
						tex_q      <= (sn_q > 0) ? x_q[5:0] : ~x_q[5:0];
						div_den_q  <= snm_c;
					end
					div_rem_q <= '0;
					div_num_q <= DW'(diffm_c) << 16;
					div_quo_q <= '0;
					div_cnt_q <= CNTW'(DW);
					dist_q    <= 1'b1;
				end else if (cell_v_c == 8'd0 && outward_c) begin
					hit_value_q <= 8'd0;
					hit_face_q  <= FACE_EAST;
					tex_q       <= 6'd0;
					dist_out_q  <= NO_HIT_DIST;
					never_hit_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign done            = done_q;
	assign hit_value       = hit_value_q;
	assign hit_face        = hit_face_q;
	assign texture_offset  = tex_q;
	assign travel_distance = dist_out_q;
	assign never_hit       = never_hit_q;

endmodule
`default_nettype wire

// File: rtl/gcr_checker.sv
// Port-level checks of the grid ray caster and their binding.
`default_nettype none
module gcr_checker
	import gcr_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic                     req_type,
	input wire logic [4:0]               cell_x,
	input wire logic [4:0]               cell_y,
	input wire logic [7:0]               cell_value,
	input wire logic [START_W-1:0]       start_x,
	input wire logic [START_W-1:0]       start_y,
	input wire logic signed [TRIG_W-1:0] ray_sine,
	input wire logic signed [TRIG_W-1:0] ray_cosine,
	input wire logic                     done,
	input wire logic [7:0]               hit_value,
	input wire logic [1:0]               hit_face,
	input wire logic [5:0]               texture_offset,
	input wire logic [30:0]              travel_distance,
	input wire logic                     never_hit
);

	// A result closes the cast, so the block is free when it shows
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	// A write item never yields a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req_type == REQ_WRITE |=> !done)
		else $error("result after a write item");

	// A cast item either occupies the block or finishes at once
	a_cast_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req_type == REQ_CAST |=> busy || done)
		else $error("cast item dropped");

	// A miss carries the fixed miss fields
	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && never_hit |-> hit_value == 8'd0 && hit_face == FACE_EAST &&
		texture_offset == 6'd0 && travel_distance == NO_HIT_DIST)
		else $error("miss fields wrong");

	// A hit is always on a wall cell
	a_hit_wall: assert property (@(posedge clk) disable iff (!arst_n)
		done && !never_hit |-> hit_value > WALL_LIMIT)
		else $error("hit on a non-wall cell");

endmodule

bind grid_ray_caster gcr_checker u_gcr_checker (.*);
`default_nettype wire

// File: verif/tb_grid_ray_caster.sv
`timescale 1ns / 1ps
// Self-checking testbench of the grid ray caster: map writes, ray casts, result scoreboard.
`default_nettype none

typedef struct {
	logic [7:0]  value;
	logic [1:0]  face;
	logic [5:0]  offset;
	logic [30:0] distance;
	logic        miss;
} ray_hit_t;

class ray_scoreboard;
	localparam int SIDE = gcr_pkg::MAP_SIDE_DEF;
	logic [7:0] grid [SIDE*SIDE];
	ray_hit_t   pending_hits [$];
	int errors, writes, casts, hits, misses;

	function void note_write(logic [4:0] cx, logic [4:0] cy, logic [7:0] val);
		grid[cy * SIDE + cx] = val;
		writes++;
	endfunction

	function logic [7:0] cell_value_at(longint x, longint y);
		if (x < 0 || y < 0)
			return 8'd0;
		if (x / 64 >= SIDE || y / 64 >= SIDE)
			return 8'd0;
		return grid[(y / 64) * SIDE + (x / 64)];
	endfunction

	// Walk the ray boundary to boundary and return the expected hit
	function ray_hit_t trace(longint sx, longint sy, longint sn, longint cs);
		ray_hit_t r;
		longint x, y, nx, ny, dx, dy, lim, fx, fy;
		int steps;
		logic [7:0] v;
		r.value = 8'd0;
		r.face = gcr_pkg::FACE_EAST;
		r.offset = 6'd0;
		r.distance = gcr_pkg::NO_HIT_DIST;
		r.miss = 1'b1;
		x = sx;
		y = sy;
		ny = (sn > 0) ? 64 : -1;
		nx = (cs > 0) ? 64 : -1;
		lim = SIDE * 64;
		steps = 0;
		if (sn == 0 && cs == 0)
			return r;
		forever begin
			dy = ny - (y & 63);
			dx = nx - (x & 63);
			steps++;
			if (steps > gcr_pkg::MAX_STEPS)
				return r;
			if ((dx * sn < 0 ? -(dx * sn) : dx * sn) < (dy * cs < 0 ? -(dy * cs) : dy * cs)) begin
				x += dx;
				y += (dx * sn) / cs;
				v = cell_value_at(x, y);
				if (v > gcr_pkg::WALL_LIMIT) begin
					fy = y & 63;
					r.value = v;
					r.face = (cs > 0) ? gcr_pkg::FACE_WEST : gcr_pkg::FACE_EAST;
					r.offset = (cs > 0) ? 6'(63 - fy) : 6'(fy);
					r.distance = 31'(((x - sx) * 65536) / cs);
					r.miss = 1'b0;
					return r;
				end
			end else begin
				x += (dy * cs) / sn;
				y += dy;
				v = cell_value_at(x, y);
				if (v > gcr_pkg::WALL_LIMIT) begin
					fx = x & 63;
					r.value = v;
					r.face = (sn > 0) ? gcr_pkg::FACE_SOUTH : gcr_pkg::FACE_NORTH;
					r.offset = (sn > 0) ? 6'(fx) : 6'(63 - fx);
					r.distance = 31'(((y - sy) * 65536) / sn);
					r.miss = 1'b0;
					return r;
				end
			end
			if (v == 0 && ((sn < 0 && y < 0) || (sn > 0 && y >= lim) ||
					(cs < 0 && x < 0) || (cs > 0 && x >= lim)))
				return r;
		end
	endfunction

	function void note_cast(logic [10:0] sx, logic [10:0] sy,
			logic signed [17:0] sn, logic signed [17:0] cs);
		ray_hit_t r;
		r = trace(longint'(sx), longint'(sy), longint'(sn), longint'(cs));
		pending_hits.push_back(r);
		casts++;
		if (r.miss)
			misses++;
		else
			hits++;
	endfunction

	function void check_hit(ray_hit_t got);
		ray_hit_t e;
		if (pending_hits.size() == 0) begin
			$display("%0t: result with no cast outstanding (value %0d dist %0d)",
				$time, got.value, got.distance);
			errors++;
			return;
		end
		e = pending_hits.pop_front();
		if (got.value !== e.value) begin
			$display("%0t: hit_value expected %0d got %0d", $time, e.value, got.value);
			errors++;
		end
		if (got.face !== e.face) begin
			$display("%0t: hit_face expected %0d got %0d", $time, e.face, got.face);
			errors++;
		end
		if (got.offset !== e.offset) begin
			$display("%0t: texture_offset expected %0d got %0d", $time, e.offset, got.offset);
			errors++;
		end
		if (got.distance !== e.distance) begin
			$display("%0t: travel_distance expected %0d got %0d", $time, e.distance,
				got.distance);
			errors++;
		end
		if (got.miss !== e.miss) begin
			$display("%0t: never_hit expected %0d got %0d", $time, e.miss, got.miss);
			errors++;
		end
	endfunction
endclass

module tb_grid_ray_caster;
	import gcr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic req_type = REQ_WRITE;
	logic [4:0] cell_x = '0;
	logic [4:0] cell_y = '0;
	logic [7:0] cell_value = '0;
	logic [START_W-1:0] start_x = '0;
	logic [START_W-1:0] start_y = '0;
	logic signed [TRIG_W-1:0] ray_sine = '0;
	logic signed [TRIG_W-1:0] ray_cosine = '0;
	logic done;
	logic [7:0] hit_value;
	logic [1:0] hit_face;
	logic [5:0] texture_offset;
	logic [30:0] travel_distance;
	logic never_hit;

	ray_scoreboard rays = new();
	int burst_left = 0;

	grid_ray_caster u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .cell_x(cell_x), .cell_y(cell_y), .cell_value(cell_value),
		.start_x(start_x), .start_y(start_y), .ray_sine(ray_sine), .ray_cosine(ray_cosine),
		.done(done), .hit_value(hit_value), .hit_face(hit_face),
		.texture_offset(texture_offset), .travel_distance(travel_distance),
		.never_hit(never_hit)
	);

	always #2 clk = ~clk;

	// Check each result in the cycle it is strobed
	always @(posedge clk) begin
		ray_hit_t got;
		if (arst_n && done) begin
			got.value = hit_value;
			got.face = hit_face;
			got.offset = texture_offset;
			got.distance = travel_distance;
			got.miss = never_hit;
			rays.check_hit(got);
		end
	end

	// Hold the item until the block takes it; start is left high
	task automatic offer_item();
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Once the current burst runs out, draw a new one and usually insert a random gap
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	endtask

	task automatic write_cell(logic [4:0] cx, logic [4:0] cy, logic [7:0] val);
		req_type <= REQ_WRITE;
		cell_x <= cx;
		cell_y <= cy;
		cell_value <= val;
		start_x <= 11'($urandom);
		start_y <= 11'($urandom);
		ray_sine <= 18'($urandom);
		ray_cosine <= 18'($urandom);
		offer_item();
		rays.note_write(cx, cy, val);
		pace();
	endtask

	task automatic cast_ray(logic [10:0] sx, logic [10:0] sy,
			logic signed [17:0] sn, logic signed [17:0] cs);
		req_type <= REQ_CAST;
		cell_x <= 5'($urandom);
		cell_y <= 5'($urandom);
		cell_value <= 8'($urandom);
		start_x <= sx;
		start_y <= sy;
		ray_sine <= sn;
		ray_cosine <= cs;
		offer_item();
		rays.note_cast(sx, sy, sn, cs);
		pace();
	endtask

	// Stop sending until every outstanding cast has returned
	task automatic drain();
		start <= 1'b0;
		while (rays.pending_hits.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic [7:0] random_cell();
		if ($urandom_range(0, 99) < 12)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(0, 127));
	endfunction

	// Cast from inside the walled room, leaving through its open north or west side
	task automatic random_cast();
		real ang;
		logic signed [17:0] sn, cs;
		ang = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
		sn = 18'($rtoi($sin(ang) * 65536.0));
		cs = 18'($rtoi($cos(ang) * 65536.0));
		case ($urandom_range(0, 9))
			0: begin
				sn = 18'($urandom_range(0, 131072)) - 18'sd65536;
				cs = 18'($urandom_range(0, 131072)) - 18'sd65536;
			end
			1: sn = 18'sd0;
			2: cs = 18'sd0;
			default: ;
		endcase
		cast_ray(11'($urandom_range(0, 447)), 11'($urandom_range(0, 447)), sn, cs);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Build an 8 by 8 room walled on its east and south sides; rays start
		// inside it, so no cast reads an unwritten cell
		for (int cy = 0; cy < 8; cy++)
			for (int cx = 0; cx < 8; cx++)
				write_cell(5'(cx), 5'(cy), (cx == 7 || cy == 7) ? 8'd255 : random_cell());

		// Directed: field extremes, axis rays, zero direction, border crossings
		write_cell(5'd31, 5'd0, 8'd128);
		write_cell(5'd5, 5'd5, 8'd127);
		write_cell(5'd6, 5'd5, 8'd0);
		cast_ray(11'd0, 11'd0, 18'sd0, 18'sd0);
		cast_ray(11'd2047, 11'd2047, 18'sd65536, 18'sd0);
		cast_ray(11'd2047, 11'd0, 18'sd0, 18'sd65536);
		cast_ray(11'd2047, 11'd2047, 18'sd0, 18'sd65536);
		cast_ray(11'd0, 11'd0, -18'sd65536, 18'sd0);
		cast_ray(11'd0, 11'd0, 18'sd0, -18'sd65536);
		cast_ray(11'd2047, 11'd2047, 18'sd46341, 18'sd46341);
		cast_ray(11'd200, 11'd200, 18'sd46341, 18'sd46341);
		cast_ray(11'd200, 11'd200, -18'sd46341, -18'sd46341);
		cast_ray(11'd200, 11'd200, 18'sd46341, -18'sd46341);
		cast_ray(11'd200, 11'd200, -18'sd46341, 18'sd46341);
		cast_ray(11'd320, 11'd350, 18'sd1, 18'sd65536);
		cast_ray(11'd320, 11'd350, -18'sd65536, -18'sd1);
		cast_ray(11'd63, 11'd64, 18'sd30000, -18'sd58000);
		cast_ray(11'd1990, 11'd10, -18'sd1, 18'sd1);
		drain();

		// Random mix of room rewrites and casts
		for (int i = 0; i < 210; i++) begin
			if ($urandom_range(0, 3) == 0)
				write_cell(5'($urandom_range(0, 6)), 5'($urandom_range(0, 6)),
					random_cell());
			else
				random_cast();
			if (i == 105)
				drain();
		end
		start <= 1'b0;

		while (rays.pending_hits.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Wrote %0d map cells and cast %0d rays: %0d struck a wall, %0d left the map.",
			rays.writes, rays.casts, rays.hits, rays.misses);
		if (rays.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Guard against a hung block
	initial begin
		#20000000;
		$display("Timeout with %0d casts outstanding", rays.pending_hits.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
